/* rtl/stream_find_and_replace_defines.svh */
// Assertion helpers shared by the find-and-replace modules
`ifndef STREAM_FIND_AND_REPLACE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SFR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define SFR_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/sfr_pkg.sv */
package sfr_pkg;

  localparam int RUN_BYTES   = 8;
  localparam int RUN_W       = RUN_BYTES * 8;
  localparam int COUNT_W     = 4;
  localparam int HELD_CNT_W  = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;

  // Configuration register indexes
  localparam logic [2:0] REG_PATTERN_BYTES      = 3'd0;
  localparam logic [2:0] REG_PATTERN_LENGTH     = 3'd1;
  localparam logic [2:0] REG_REPLACEMENT_BYTES  = 3'd2;
  localparam logic [2:0] REG_REPLACEMENT_LENGTH = 3'd3;

  typedef struct packed {
    logic [RUN_W-1:0]   pattern_bytes;
    logic [COUNT_W-1:0] pattern_length;
    logic [RUN_W-1:0]   replacement_bytes;
    logic [COUNT_W-1:0] replacement_length;
  } cfg_t;

  // One run of output words produced by a single input word
  typedef struct packed {
    logic [RUN_W-1:0]   bytes;
    logic [COUNT_W-1:0] count;
  } run_t;

  typedef enum logic [1:0] {
    KIND_FLUSH,
    KIND_LINE,
    KIND_REPLACE,
    KIND_SCAN
  } kind_t;

endpackage

/* rtl/sfr_queue.sv */
`include "stream_find_and_replace_defines.svh"

module sfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sfr_pkg::run_t push_run,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output sfr_pkg::run_t head_run
);
  import sfr_pkg::*;

  run_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [1:0]        count;

  assign full       = (count == 2'(QUEUE_DEPTH));
  assign head_valid = (count != 2'd0);
  assign head_run   = slots[rd_ptr];

  // Store incoming run
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_run;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  `SFR_ASSERT_IMP(a_no_push_full, clk, rst, push, !full || pop, "queue written while full")
  `SFR_ASSERT_IMP(a_no_pop_empty, clk, rst, pop, head_valid, "queue read while empty")
  `SFR_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= 2'(QUEUE_DEPTH), "queue overfilled")

endmodule

/* rtl/sfr_front.sv */
`include "stream_find_and_replace_defines.svh"

module sfr_front #(
  parameter int MAX_PATTERN = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          end_of_stream,
  input  sfr_pkg::cfg_t cfg,
  input  logic          q_full,
  output logic          q_push,
  output sfr_pkg::run_t q_run
);
  import sfr_pkg::*;

  localparam int HELD_DEPTH = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

  logic [7:0]            held [HELD_DEPTH];
  logic [7:0]            held_next [HELD_DEPTH];
  logic [HELD_CNT_W-1:0] held_count;
  logic [HELD_CNT_W-1:0] held_count_next;

  logic [7:0]         text_b [RUN_BYTES];
  logic [7:0]         pat_b  [RUN_BYTES];
  logic [RUN_W-1:0]   text_w;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] plen;
  logic [COUNT_W-1:0] rlen;
  logic [RUN_BYTES-1:0] cand;
  logic [COUNT_W-1:0] sel;
  logic               full_match;
  kind_t              kind;
  logic               accept;

  function automatic logic [COUNT_W-1:0] clamp_len(input logic [COUNT_W-1:0] v,
                                                   input logic [COUNT_W-1:0] cap);
    logic [COUNT_W-1:0] r;
    r = v;
    if (r == '0) r = COUNT_W'(1);
    if (r > cap) r = cap;
    return r;
  endfunction

  assign plen   = clamp_len(cfg.pattern_length, COUNT_W'(MAX_PATTERN));
  assign rlen   = clamp_len(cfg.replacement_length, COUNT_W'(RUN_BYTES));
  assign n      = {1'b0, held_count} + COUNT_W'(1);
  assign in_ready = !q_full;
  assign accept = in_valid && in_ready;

  // Line up held bytes followed by the new byte
  for (genvar gi = 0; gi < RUN_BYTES; gi++) begin : g_text
    assign pat_b[gi] = cfg.pattern_bytes[gi*8 +: 8];
    assign text_w[gi*8 +: 8] = text_b[gi];
    if (gi < HELD_DEPTH) begin : g_held
      assign text_b[gi] = (COUNT_W'(gi) < {1'b0, held_count}) ? held[gi] :
                          (COUNT_W'(gi) == {1'b0, held_count}) ? data_byte : 8'd0;
    end else begin : g_new
      assign text_b[gi] = (COUNT_W'(gi) == {1'b0, held_count}) ? data_byte : 8'd0;
    end
  end

  // Check every start for a proper pattern prefix reaching the end
  always_comb begin
    logic hit;
    for (int s = 0; s < RUN_BYTES; s++) begin
      hit = (COUNT_W'(s) < n) && ((n - COUNT_W'(s)) < plen);
      for (int i = 0; i < RUN_BYTES; i++) begin
        if ((s + i < RUN_BYTES) && (COUNT_W'(i) < n - COUNT_W'(s))) begin
          if (text_b[s+i] != pat_b[i]) hit = 1'b0;
        end
      end
      cand[s] = hit;
    end
  end

  // Earliest such start; none means release everything
  always_comb begin
    sel = n;
    for (int s = RUN_BYTES - 1; s >= 0; s--) begin
      if (cand[s]) sel = COUNT_W'(s);
    end
  end

  // Whole pattern present
  always_comb begin
    logic eq;
    eq = 1'b1;
    for (int i = 0; i < RUN_BYTES; i++) begin
      if ((COUNT_W'(i) < n) && (text_b[i] != pat_b[i])) eq = 1'b0;
    end
    full_match = eq && (n == plen);
  end

  // Classify the word
  always_comb begin
    if (end_of_stream) begin
      kind = KIND_FLUSH;
    end else if (data_byte == NEWLINE_BYTE) begin
      kind = KIND_LINE;
    end else if (full_match) begin
      kind = KIND_REPLACE;
    end else begin
      kind = KIND_SCAN;
    end
  end

  // Build the run and the next held state
  always_comb begin
    q_run.bytes     = text_w;
    q_run.count     = '0;
    held_count_next = '0;
    case (kind)
      KIND_FLUSH: begin
        q_run.count = {1'b0, held_count};
      end
      KIND_LINE: begin
        q_run.count = n;
      end
      KIND_REPLACE: begin
        q_run.bytes = cfg.replacement_bytes;
        q_run.count = rlen;
      end
      KIND_SCAN: begin
        q_run.count     = sel;
        held_count_next = HELD_CNT_W'(n - sel);
      end
      default: begin
        q_run.count = '0;
      end
    endcase
  end

  // Shift the surviving tail down to the front
  always_comb begin
    for (int j = 0; j < HELD_DEPTH; j++) begin
      held_next[j] = 8'd0;
      for (int s = 0; s < RUN_BYTES; s++) begin
        if ((sel == COUNT_W'(s)) && (s + j < RUN_BYTES)) held_next[j] = text_b[s+j];
      end
    end
  end

  assign q_push = accept && (q_run.count != '0);

  // Hold partial match bytes
  always_ff @(posedge clk) begin
    if (accept && kind == KIND_SCAN) begin
      for (int j = 0; j < HELD_DEPTH; j++) begin
        held[j] <= held_next[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (accept) begin
      held_count <= held_count_next;
    end
  end

  `SFR_ASSERT_IMP(a_held_bound, clk, rst, 1'b1, 32'(held_count) < MAX_PATTERN, "held count too large")
  `SFR_ASSERT_IMP(a_line_clears, clk, rst, accept && kind == KIND_LINE, q_push && q_run.count == n, "newline run lost")
  `SFR_ASSERT_NXT(a_replace_clears, clk, rst, accept && kind != KIND_SCAN, held_count == '0, "held bytes kept after release")

endmodule

/* rtl/sfr_back.sv */
`include "stream_find_and_replace_defines.svh"

module sfr_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  sfr_pkg::run_t head_run,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_of_run
);
  import sfr_pkg::*;

  run_t               run;
  logic               run_valid;
  logic [2:0]         idx;
  logic               out_take;

  assign out_valid   = run_valid;
  assign out_byte    = run.bytes[{idx, 3'b000} +: 8];
  assign last_of_run = ({1'b0, idx} == run.count - COUNT_W'(1));
  assign out_take    = out_valid && out_ready;
  assign pop         = head_valid && (!run_valid || (out_take && last_of_run));

  // Load the next run
  always_ff @(posedge clk) begin
    if (pop) begin
      run <= head_run;
    end
  end

  // Step through the words of the current run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= '0;
    end else if (pop) begin
      run_valid <= 1'b1;
      idx       <= '0;
    end else if (out_take) begin
      if (last_of_run) begin
        run_valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  `SFR_ASSERT_IMP(a_run_nonempty, clk, rst, run_valid, run.count != '0, "empty run loaded")
  `SFR_ASSERT_IMP(a_idx_in_run, clk, rst, run_valid, {1'b0, idx} < run.count, "index beyond run")
  `SFR_ASSERT_IMP(a_pop_free, clk, rst, pop, !run_valid || out_take, "run replaced early")

endmodule

/* rtl/stream_find_and_replace.sv */
// Streaming find-and-replace over a byte stream.
// Input channel (in_valid/in_ready): one word per text byte in data_byte, or
// end_of_stream=1 to release bytes held as a partial match (data_byte ignored).
// Output channel (out_valid/out_ready): rewritten bytes in out_byte, with
// last_of_run high on the final word caused by one input word; an input that
// causes nothing produces no output word.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0
// pattern bytes, 1 pattern length, 2 replacement bytes, 3 replacement length;
// first byte in bits 7..0. Other indexes are ignored. cfg_ready is always high.
// Write it only while the block is idle.
// An accepted input word passes through the run queue and the back's run register before its first output word.
// Throughput: the front classifies one input word per cycle while the queue is not full;
// the back emits one output word per cycle while out_ready is high. A two-entry run
// queue between them absorbs short bursts.
// Reset: held bytes dropped, queue and output emptied, pattern and replacement
// set to one zero byte each.
// Receiver stall: the output holds its word; once the queue fills, in_ready
// falls until the back frees an entry.
module stream_find_and_replace #(
  parameter int MAX_PATTERN = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import sfr_pkg::*;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  run_t q_run;
  logic q_pop;
  logic q_head_valid;
  run_t q_head;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_bytes      <= '0;
      cfg.pattern_length     <= COUNT_W'(1);
      cfg.replacement_bytes  <= '0;
      cfg.replacement_length <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PATTERN_BYTES:      cfg.pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     cfg.pattern_length     <= cfg_data[COUNT_W-1:0];
        REG_REPLACEMENT_BYTES:  cfg.replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: cfg.replacement_length <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  sfr_front #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .end_of_stream (end_of_stream),
    .cfg           (cfg),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_run         (q_run)
  );

  sfr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_run   (q_run),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_run   (q_head)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (q_head_valid),
    .head_run    (q_head),
    .pop         (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .last_of_run (last_of_run)
  );

endmodule
